@@ rtl/lsll_pkg.sv @@
// ---------------------------------------------------------------------------
// Longest subnet link lookup package
// Shared sizes, mode and record codes, the table entry layout and the
// link byte mask helper.
// ---------------------------------------------------------------------------
package lsll_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int LINK_BYTES    = 8;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int S_DATA_W = 136;
	localparam int S_USER_W = 5;
	localparam int M_DATA_W = 136;
	localparam int M_USER_W = 1;

	// Operation codes carried in the low bits of s_tuser
	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Record families of a load
	typedef enum logic [1:0] {
		KIND_LINK  = 2'd0,
		KIND_IPV4  = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	// Lookup sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic        has_link;
		logic [3:0]  link_len;
		logic [63:0] link;
		logic [31:0] mask;
		logic [31:0] ip;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Byte mask that keeps the low len bytes of a link address
	function automatic logic [63:0] link_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

@@ rtl/lsll_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module lsll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/longest_subnet_link_lookup_unit.sv @@
// ---------------------------------------------------------------------------
// Longest subnet link lookup unit
// Clear and load beats are taken only while the sequencer is idle. A lookup
// walks the stored entries in turn through the single table read port,
// feeding one shared mask comparator, then passes the last and finish
// states to a registered result; with an empty table it goes straight to
// the finish state. No new beat is taken until the lookup is through, and
// a held reply stalls the next lookup before its result stage.
// Reset clears the sequencer, entry count and current link; table contents
// stay undefined and need no clearing pass.
// ---------------------------------------------------------------------------
module longest_subnet_link_lookup_unit
	import lsll_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// ip_address, net_mask, link_address, link_length, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// mode, entry_kind, broadcast_capable
	input  logic [S_USER_W-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// query_address, found_link_address, found_link_length, best_mask, zero pad
	output logic [M_DATA_W-1:0] m_tdata,
	// link_found
	output logic [M_USER_W-1:0] m_tuser
);

	// Input beat fields
	mode_t       in_mode;
	kind_t       in_kind;
	logic        in_bcast;
	logic [31:0] in_ip;
	logic [31:0] in_mask;
	logic [63:0] in_link;
	logic [3:0]  in_len;
	logic [3:0]  sat_len;
	logic        in_acc;

	assign in_mode  = mode_t'(s_tuser[1:0]);
	assign in_kind  = kind_t'(s_tuser[3:2]);
	assign in_bcast = s_tuser[4];
	assign in_ip    = s_tdata[31:0];
	assign in_mask  = s_tdata[63:32];
	assign in_link  = s_tdata[127:64];
	assign in_len   = s_tdata[131:128];
	assign in_acc   = s_tvalid && s_tready;
	assign sat_len  = (in_len > 4'(LINK_BYTES)) ? 4'(LINK_BYTES) : in_len;

	// Sequencer and table state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              cmp_vld_q;
	logic [63:0]       cur_link_q;
	logic [3:0]        cur_len_q;
	logic              cur_valid_q;
	logic [31:0]       query_q;

	// Best match so far
	logic              matched_q;
	logic [31:0]       best_mask_q;
	logic [63:0]       best_link_q;
	logic [3:0]        best_len_q;
	logic              best_has_q;

	// Output register
	logic              m_valid_q;
	logic [31:0]       out_query_q;
	logic              out_found_q;
	logic [63:0]       out_link_q;
	logic [3:0]        out_len_q;
	logic [31:0]       out_mask_q;

	// Sequencer outputs
	logic              rd_en;
	logic              fin;
	logic              last_idx;
	logic              lookup_go;

	// Table RAM ports
	logic              wr_en;
	entry_t            wr_entry;
	entry_t            rd_entry;
	logic [ENTRY_W-1:0] rd_word;

	assign last_idx  = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
	assign lookup_go = in_acc && (in_mode == MODE_LOOKUP);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (lookup_go) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_idx) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		fin      = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   rd_en = 1'b1;
			ST_LAST:   rd_en = 1'b0;
			ST_FINISH: fin = !m_valid_q || m_tready;
			default:   s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= rd_en;
		end
	end

	// Walk the table index
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			idx_q <= '0;
		end else if (rd_en && !last_idx) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Table writes: append broadcast IPv4 records while room remains
	assign wr_en = in_acc && (in_mode == MODE_LOAD) && (in_kind == KIND_IPV4) && in_bcast
		&& (count_q < CNT_W'(TABLE_ENTRIES));

	always_comb begin
		wr_entry.has_link = cur_valid_q;
		wr_entry.link_len = cur_len_q;
		wr_entry.link     = cur_link_q;
		wr_entry.mask     = in_mask;
		wr_entry.ip       = in_ip;
	end

	lsll_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_word)
	);

	assign rd_entry = entry_t'(rd_word);

	// Entry count and current link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_link_q  <= '0;
			cur_len_q   <= '0;
			cur_valid_q <= 1'b0;
		end else begin
			if (in_acc && (in_mode == MODE_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (in_acc && (in_mode == MODE_LOAD) && (in_kind == KIND_LINK)) begin
				cur_link_q  <= in_link & link_mask(sat_len);
				cur_len_q   <= sat_len;
				cur_valid_q <= 1'b1;
			end
		end
	end

	// Shared comparator: subnet hit with a strictly larger mask
	logic hit;
	assign hit = cmp_vld_q && (((rd_entry.ip ^ query_q) & rd_entry.mask) == 32'd0)
		&& (!matched_q || (rd_entry.mask > best_mask_q));

	// Track the best entry
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			query_q   <= in_ip;
			matched_q <= 1'b0;
		end else if (hit) begin
			matched_q   <= 1'b1;
			best_mask_q <= rd_entry.mask;
			best_link_q <= rd_entry.link;
			best_len_q  <= rd_entry.link_len;
			best_has_q  <= rd_entry.has_link;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_query_q <= query_q;
			out_found_q <= matched_q && best_has_q;
			out_link_q  <= (matched_q && best_has_q) ? best_link_q : 64'd0;
			out_len_q   <= (matched_q && best_has_q) ? best_len_q : 4'd0;
			out_mask_q  <= matched_q ? best_mask_q : 32'd0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_mask_q, out_len_q, out_link_q, out_query_q};
	assign m_tuser  = out_found_q;

endmodule

@@ sim/lsll_reply_checker.sv @@
// ---------------------------------------------------------------------------
// Longest subnet link lookup reply checker
// Watches both stream channels of the lookup unit. Keeps its own copy of
// the interface table and the current link, works out the reply of every
// accepted lookup beat and compares each reply beat, field by field, with
// the oldest one still waiting.
// ---------------------------------------------------------------------------
module lsll_reply_checker
	import lsll_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// ip_address, net_mask, link_address, link_length, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// mode, entry_kind, broadcast_capable
	input  logic [S_USER_W-1:0] s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// query_address, found_link_address, found_link_length, best_mask, zero pad
	input  logic [M_DATA_W-1:0] m_tdata,
	// link_found
	input  logic [M_USER_W-1:0] m_tuser,
	output int                  fail_count,
	output int                  pending_count
);

	typedef struct {
		logic [31:0] query;
		logic        found;
		logic [63:0] link;
		logic [3:0]  link_len;
		logic [31:0] mask;
	} lookup_reply_t;

	// Shadow interface table and current link
	entry_t        routes [TABLE_ENTRIES];
	int            route_count;
	logic [63:0]   cur_link;
	logic [3:0]    cur_link_len;
	logic          cur_link_valid;

	lookup_reply_t awaited_replies [$];
	int            fails;

	// Pick the longest matching subnet; the earliest entry wins a tie
	function automatic lookup_reply_t predict_reply(input logic [31:0] query);
		lookup_reply_t r;
		logic          hit;
		int            best;
		hit  = 1'b0;
		best = 0;
		for (int i = 0; i < route_count; i++) begin
			if (((routes[i].ip ^ query) & routes[i].mask) == 32'd0 &&
			    (!hit || routes[i].mask > routes[best].mask)) begin
				hit  = 1'b1;
				best = i;
			end
		end
		r.query = query;
		r.found = hit && routes[best].has_link;
		r.link     = r.found ? routes[best].link : 64'd0;
		r.link_len = r.found ? routes[best].link_len : 4'd0;
		r.mask     = hit ? routes[best].mask : 32'd0;
		return r;
	endfunction

	// Apply one accepted request beat to the shadow state
	task automatic absorb_request(input logic [S_DATA_W-1:0] data,
	                              input logic [S_USER_W-1:0] user);
		logic [3:0]  len;
		logic [63:0] keep;
		len = data[131:128];
		case (mode_t'(user[1:0]))
			MODE_CLEAR: begin
				route_count = 0;
			end
			MODE_LOAD: begin
				if (kind_t'(user[3:2]) == KIND_LINK) begin
					if (len > LINK_BYTES)
						len = 4'(LINK_BYTES);
					keep = (len >= 4'd8) ? {64{1'b1}} : ((64'd1 << (len * 8)) - 64'd1);
					cur_link       = data[127:64] & keep;
					cur_link_len   = len;
					cur_link_valid = 1'b1;
				end else if (kind_t'(user[3:2]) == KIND_IPV4 && user[4] &&
				             route_count < TABLE_ENTRIES) begin
					routes[route_count].ip       = data[31:0];
					routes[route_count].mask     = data[63:32];
					routes[route_count].link     = cur_link;
					routes[route_count].link_len = cur_link_len;
					routes[route_count].has_link = cur_link_valid;
					route_count++;
				end
			end
			MODE_LOOKUP: begin
				awaited_replies.push_back(predict_reply(data[31:0]));
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string field, input logic [63:0] exp_val,
	                             input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: reply %s mismatch, expected %h, actual %h",
			         $time, field, exp_val, act_val);
			fails++;
		end
	endtask

	// Retire reply beats first, then take in request beats
	always @(posedge clk or negedge arst_n) begin
		lookup_reply_t exp_reply;
		if (!arst_n) begin
			route_count    = 0;
			cur_link       = '0;
			cur_link_len   = '0;
			cur_link_valid = 1'b0;
			fails          = 0;
			awaited_replies.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t: reply beat with none expected, actual data %h user %h",
					         $time, m_tdata, m_tuser);
					fails++;
				end else begin
					exp_reply = awaited_replies.pop_front();
					compare_field("query_address", 64'(exp_reply.query), 64'(m_tdata[31:0]));
					compare_field("link_found", 64'(exp_reply.found), 64'(m_tuser[0]));
					compare_field("found_link_address", exp_reply.link, m_tdata[95:32]);
					compare_field("found_link_length", 64'(exp_reply.link_len),
					              64'(m_tdata[99:96]));
					compare_field("best_mask", 64'(exp_reply.mask), 64'(m_tdata[131:100]));
				end
			end
			if (s_tvalid && s_tready)
				absorb_request(s_tdata, s_tuser);
			fail_count    <= fails;
			pending_count <= awaited_replies.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// Longest subnet link lookup unit testbench
// Drives clear, load and lookup beats into the unit: a directed opening on
// the corner cases, then rounds of table fills followed by lookups that hit
// the stored subnets, mixed with random noise. Both sides idle at random in
// several phases; the checker beside the unit predicts and compares replies.
// ---------------------------------------------------------------------------
module testbench
	import lsll_pkg::*;
();

	localparam int ITEM_TARGET = 1700;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                s_tvalid       = 1'b0;
	logic [S_DATA_W-1:0] s_tdata        = '0;
	logic [S_USER_W-1:0] s_tuser        = '0;
	logic                m_tready       = 1'b0;
	wire                 s_tready;
	wire                 m_tvalid;
	wire  [M_DATA_W-1:0] m_tdata;
	wire  [M_USER_W-1:0] m_tuser;
	int                  fail_count;
	int                  pending_count;

	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;
	int                  hold_requests  = 0;
	int                  hold_served    = 0;
	int                  hold_left      = 0;
	int                  cycle_count    = 0;
	int                  items_sent     = 0;
	logic [31:0]         loaded_ip [$];
	logic [31:0]         loaded_mask [$];

	longest_subnet_link_lookup_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lsll_reply_checker reply_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the reply channel at random, or for a long stretch on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_requests != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Offer one request beat and hold it until the unit takes it
	task automatic send_request(input mode_t mode, input kind_t kind, input logic bcast,
	                            input logic [31:0] ip, input logic [31:0] mask,
	                            input logic [63:0] link, input logic [3:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, len, link, mask, ip};
		s_tuser  <= {bcast, kind, mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// Track stored subnets so lookups can aim at them
		case (mode)
			MODE_CLEAR: begin
				loaded_ip.delete();
				loaded_mask.delete();
				items_sent++;
			end
			MODE_LOAD: begin
				if (kind == KIND_LINK) begin
					items_sent++;
				end else if (kind == KIND_IPV4 && bcast && loaded_ip.size() < TABLE_ENTRIES) begin
					loaded_ip.push_back(ip);
					loaded_mask.push_back(mask);
					items_sent++;
				end
			end
			MODE_LOOKUP: begin
				items_sent++;
			end
			default: begin
			end
		endcase
	endtask

	// Lower valid and wait until every reply has come back
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	function automatic logic [63:0] rand_link();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_mask();
		int bits;
		if ($urandom_range(99) < 15)
			return $urandom;
		if ($urandom_range(1) == 0)
			bits = 8 * $urandom_range(0, 4);
		else
			bits = $urandom_range(0, 32);
		return (bits == 0) ? 32'd0 : ({32{1'b1}} << (32 - bits));
	endfunction

	// Aim most queries inside a stored subnet
	function automatic logic [31:0] pick_query();
		int idx;
		if (loaded_ip.size() > 0 && $urandom_range(99) < 75) begin
			idx = $urandom_range(loaded_ip.size() - 1);
			return loaded_ip[idx] ^ ($urandom & ~loaded_mask[idx]);
		end
		return $urandom;
	endfunction

	task automatic load_link();
		send_request(MODE_LOAD, KIND_LINK, 1'($urandom_range(1)), $urandom, $urandom,
		             rand_link(), 4'($urandom_range(15)));
	endtask

	// Clear, fill the table with overlapping subnets, then look them up
	task automatic table_round();
		logic [31:0] base;
		int          fill;
		int          queries;
		base    = $urandom;
		fill    = $urandom_range(0, 20);
		queries = $urandom_range(1, 10);
		send_request(MODE_CLEAR, kind_t'($urandom_range(3)), 1'($urandom_range(1)),
		             $urandom, $urandom, rand_link(), 4'($urandom_range(15)));
		for (int i = 0; i < fill; i++) begin
			if ($urandom_range(99) < 35)
				load_link();
			if ($urandom_range(99) < 10)
				send_request(MODE_LOAD, kind_t'($urandom_range(3)), 1'b0, $urandom,
				             $urandom, rand_link(), 4'($urandom_range(15)));
			send_request(MODE_LOAD, KIND_IPV4, 1'b1,
			             base ^ ($urandom & ({32{1'b1}} >> $urandom_range(8, 32))),
			             rand_mask(), rand_link(), 4'($urandom_range(15)));
		end
		for (int i = 0; i < queries; i++) begin
			if ($urandom_range(99) < 10)
				load_link();
			send_request(MODE_LOOKUP, kind_t'($urandom_range(3)), 1'($urandom_range(1)),
			             pick_query(), $urandom, rand_link(), 4'($urandom_range(15)));
		end
	endtask

	// Send beats with every field random, ignored modes and kinds included
	task automatic noise_round();
		for (int i = 0; i < 10; i++) begin
			send_request(mode_t'($urandom_range(3)), kind_t'($urandom_range(3)),
			             1'($urandom_range(1)),
			             ($urandom_range(1) == 0) ? pick_query() : $urandom,
			             rand_mask(), rand_link(), 4'($urandom_range(15)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, then an entry loaded before any link record
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'hFFFF_FFFF, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'h0A00_0001, 32'hFF00_0000, 64'd0, 4'd0);
		// Short link trimmed to its bytes, then an oversized length saturated
		send_request(MODE_LOAD, KIND_LINK, 1'b0, 32'd0, 32'd0, {64{1'b1}}, 4'd6);
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_LINK, 1'b1, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
		// Same mask as an earlier entry: the earlier one must win
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'h0A01_FFFF, 32'hFFFF_0000, 64'd0, 4'd0);
		// Zero-length link still counts as present
		send_request(MODE_LOAD, KIND_LINK, 1'b0, 32'd0, 32'd0, {64{1'b1}}, 4'd0);
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'h0A01_0200, 32'hFFFF_FF00, 64'd0, 4'd0);
		// Records the unit must drop
		send_request(MODE_LOAD, KIND_IPV4, 1'b0, 32'h0A01_0203, {32{1'b1}}, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_OTHER, 1'b1, 32'h0A01_0203, {32{1'b1}}, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_RSVD, 1'b1, 32'h0A01_0203, {32{1'b1}}, 64'd0, 4'd0);
		send_request(MODE_NONE, KIND_IPV4, 1'b1, 32'h0A01_0203, {32{1'b1}}, {64{1'b1}},
		             4'd15);
		// Default route and host route
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'd0, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, {32{1'b1}}, {32{1'b1}}, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'h0A01_0203, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'h0A01_F0F0, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'h0A7F_0000, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'hC0A8_0001, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, {32{1'b1}}, 32'd0, 64'd0, 4'd0);
		// Clear keeps the current link
		send_request(MODE_CLEAR, KIND_LINK, 1'b0, 32'd0, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'h0A01_0203, 32'd0, 64'd0, 4'd0);
		send_request(MODE_LOAD, KIND_IPV4, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 64'd0, 4'd0);
		send_request(MODE_LOOKUP, KIND_LINK, 1'b0, 32'h0A00_0005, 32'd0, 64'd0, 4'd0);
		drain_replies();

		// Idle phases: none, sender, receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 63; end
				default: begin send_idle_pct = 34; recv_stall_pct <= 34; end
			endcase
			if (phase == 0) begin
				// Hold off replies while requests keep coming, so the unit backs up
				hold_requests <= hold_requests + 1;
				table_round();
				table_round();
			end
			while (items_sent < ITEM_TARGET * (phase + 1) / 4) begin
				if ($urandom_range(99) < 85)
					table_round();
				else
					noise_round();
			end
			drain_replies();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
